@@ design/vbdma_pkg.sv @@
package vbdma_pkg;

  // Transfer phase of the copy engine.
  typedef enum logic [1:0] {
    PH_INACTIVE = 2'd0,
    PH_STARTING = 2'd1,
    PH_ACTIVE   = 2'd2,
    PH_PAUSED   = 2'd3
  } phase_e;

  // Kind of an input item.
  typedef enum logic [1:0] {
    CMD_WRITE  = 2'd0,
    CMD_READ   = 2'd1,
    CMD_TICK   = 2'd2,
    CMD_HBLANK = 2'd3
  } cmd_e;

  // Register selects for register-write items.
  localparam logic [2:0] SEL_SRC_HI  = 3'd0;
  localparam logic [2:0] SEL_SRC_LO  = 3'd1;
  localparam logic [2:0] SEL_DST_HI  = 3'd2;
  localparam logic [2:0] SEL_DST_LO  = 3'd3;
  localparam logic [2:0] SEL_CONTROL = 3'd4;

  // Configuration register index (byte address bit 2 selects the register).
  localparam logic CFG_IDX_COLOR_MODE = 1'b0;

  // Result queue geometry.
  localparam int unsigned OUT_DEPTH = 4;
  localparam int unsigned OUT_PTR_W = $clog2(OUT_DEPTH);
  localparam int unsigned OUT_CNT_W = OUT_PTR_W + 1;

  // One result item.
  typedef struct packed {
    logic [7:0]  read_data;
    logic        copy_valid;
    logic [15:0] source_addr;
    logic [12:0] dest_offset;
    logic        last;
  } result_t;

endpackage

@@ design/vbdma_out_fifo.sv @@
module vbdma_out_fifo (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [1:0]        push_n_i,
  input  vbdma_pkg::result_t push0_i,
  input  vbdma_pkg::result_t push1_i,
  output logic              space_o,
  output logic              valid_o,
  output vbdma_pkg::result_t data_o,
  input  logic              pop_i
);
  import vbdma_pkg::*;

  result_t                mem_q [OUT_DEPTH];
  logic [OUT_PTR_W-1:0]   wr_ptr_q, wr_ptr_d;
  logic [OUT_PTR_W-1:0]   rd_ptr_q, rd_ptr_d;
  logic [OUT_CNT_W-1:0]   count_q, count_d;
  logic                   pop;
  logic [OUT_PTR_W-1:0]   wr_ptr_nxt;

  assign valid_o    = (count_q != '0);
  assign data_o     = mem_q[rd_ptr_q];
  // Room for the largest burst one item can cause.
  assign space_o    = (count_q <= OUT_CNT_W'(OUT_DEPTH - 2));
  assign pop        = pop_i && valid_o;
  assign wr_ptr_nxt = wr_ptr_q + OUT_PTR_W'(1);

  always_comb begin
    wr_ptr_d = wr_ptr_q + OUT_PTR_W'(push_n_i);
    rd_ptr_d = pop ? rd_ptr_q + OUT_PTR_W'(1) : rd_ptr_q;
    count_d  = count_q + OUT_CNT_W'(push_n_i) - OUT_CNT_W'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_n_i != 2'd0) begin
      mem_q[wr_ptr_q] <= push0_i;
    end
    if (push_n_i == 2'd2) begin
      mem_q[wr_ptr_nxt] <= push1_i;
    end
  end

endmodule

@@ design/vram_block_dma_controller_unit.sv @@
// Video memory block DMA controller. Each input item is a register write
// (source high/low, destination high/low, control), a control read, a tick or
// a horizontal-blank pulse, selected by s_axis_tuser. A control write starts a
// general transfer (bit 7 clear) or a blanking transfer (bit 7 set) of
// ((control & 0x7F) + 1) * 16 bytes; a control write with bit 7 clear while a
// transfer runs cancels it. While a transfer runs, every fourth tick performs
// one step: the first step after a start or resume only arms the transfer,
// later steps emit up to two copy result items, each carrying a mapped source
// address (addresses at or above 0xE000 are mirrored down by 0x2000) and a
// 13-bit video memory offset. Blanking transfers move 16 bytes per blank and
// then pause until the next blank pulse. A control read returns one result
// item with the status byte (0xFF while color_mode is 0). The block takes one
// input item per cycle: all state updates for an item happen in the cycle it
// is accepted, and its results go into a four-entry result queue that drains
// one item per cycle on the master side. The input stalls only when that
// queue has fewer than two free entries, so the sustained rate is one input
// item per cycle as long as the downstream side keeps up with one result
// item per cycle. The APB port holds the single color_mode register at byte
// address 0 (reset value 1).
module vram_block_dma_controller_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Input items.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [2:0] reg_select, [10:3] write_data, [12:11] lcd_mode, [15:13] zero
  input  logic [15:0] s_axis_tdata,
  // [1:0] command
  input  logic [1:0]  s_axis_tuser,
  // Result items.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [7:0] read_data, [23:8] source_addr, [36:24] dest_offset, [39:37] zero
  output logic [39:0] m_axis_tdata,
  // [0] copy_valid
  output logic [0:0]  m_axis_tuser,
  output logic        m_axis_tlast,
  // Configuration port.
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import vbdma_pkg::*;

  // Architectural state.
  logic        color_mode_q, color_mode_d;
  logic [15:0] src_q, src_d;
  logic [12:0] dst_q, dst_d;
  logic [7:0]  cs_q, cs_d;
  logic [11:0] bytes_q, bytes_d;
  logic [4:0]  blank_q, blank_d;
  phase_e      phase_q, phase_d;
  logic        blank_mode_q, blank_mode_d;
  logic [2:0]  div_q, div_d;

  // Decoded input item.
  logic        in_acc;
  cmd_e        cmd;
  logic [2:0]  sel;
  logic [7:0]  wdata;
  logic [1:0]  lcd;

  // Events that move the transfer phase.
  logic        ctrl_wr;
  logic        xfer_start;
  logic        step_due;
  logic        copy_due;
  logic        blank_resume;

  // Copy step helpers.
  logic [1:0]  n_total;
  logic [1:0]  n_copy;
  logic [11:0] bytes_left;
  logic [4:0]  blank_left;
  logic [2:0]  div_dec;
  logic [15:0] src_inc;
  logic [12:0] dst_inc;

  // Results of this item.
  result_t     res0, res1;
  logic [1:0]  push_n;
  logic        q_space;
  result_t     q_data;
  logic        cfg_wr;

  // Addresses in the echo region are folded down by 0x2000.
  function automatic logic [15:0] mirror_addr(input logic [15:0] a);
    logic [15:0] r;
    r = a;
    if (a[15:13] == 3'b111) begin
      r = {3'b110, a[12:0]};
    end
    return r;
  endfunction

  assign in_acc = s_axis_tvalid && s_axis_tready;
  assign cmd    = cmd_e'(s_axis_tuser);
  assign sel    = s_axis_tdata[2:0];
  assign wdata  = s_axis_tdata[10:3];
  assign lcd    = s_axis_tdata[12:11];

  assign s_axis_tready = q_space;

  // Number of bytes the next copy step moves: at most two, bounded by the
  // whole-transfer count and, in blanking mode, by the per-blank count.
  always_comb begin
    n_total = (bytes_q < 12'd2) ? bytes_q[1:0] : 2'd2;
    n_copy  = n_total;
    if (blank_mode_q && (blank_q < {3'b000, n_total})) begin
      n_copy = blank_q[1:0];
    end
  end

  assign bytes_left = bytes_q - {10'd0, n_copy};
  assign blank_left = blank_mode_q ? (blank_q - {3'b000, n_copy}) : blank_q;
  assign div_dec    = div_q - 3'd1;
  assign src_inc    = src_q + 16'd1;
  assign dst_inc    = dst_q + 13'd1;

  // A control write either (re)starts a transfer or cancels the running one.
  assign ctrl_wr      = in_acc && (cmd == CMD_WRITE) && color_mode_q && (sel == SEL_CONTROL);
  assign xfer_start   = ctrl_wr && ((phase_q == PH_INACTIVE) || wdata[7]);
  // The tick that brings the divider to zero performs one engine step.
  assign step_due     = in_acc && (cmd == CMD_TICK) &&
                        ((phase_q == PH_STARTING) || (phase_q == PH_ACTIVE)) &&
                        (div_dec == 3'd0);
  assign copy_due     = step_due && (phase_q == PH_ACTIVE);
  assign blank_resume = in_acc && (cmd == CMD_HBLANK) && (phase_q == PH_PAUSED);

  // Next transfer phase.
  always_comb begin
    phase_d = phase_q;
    if (xfer_start) begin
      phase_d = (wdata[7] && (lcd != 2'd0)) ? PH_PAUSED : PH_STARTING;
    end else if (ctrl_wr) begin
      phase_d = PH_INACTIVE;
    end else if (step_due) begin
      if (phase_q == PH_STARTING) begin
        phase_d = PH_ACTIVE;
      end else if (bytes_left == 12'd0) begin
        phase_d = PH_INACTIVE;
      end else if (blank_mode_q && (blank_left == 5'd0)) begin
        phase_d = PH_PAUSED;
      end
    end else if (blank_resume) begin
      phase_d = PH_STARTING;
    end
  end

  // Result items caused by this input item.
  always_comb begin
    res0   = '0;
    res1   = '0;
    push_n = 2'd0;
    if (in_acc && (cmd == CMD_READ)) begin
      res0.read_data = color_mode_q ? cs_q : 8'hFF;
      res0.last      = 1'b1;
      push_n         = 2'd1;
    end else if (copy_due) begin
      res0.copy_valid  = 1'b1;
      res0.source_addr = mirror_addr(src_q);
      res0.dest_offset = dst_q;
      res0.last        = (n_copy == 2'd1);
      res1.copy_valid  = 1'b1;
      res1.source_addr = mirror_addr(src_inc);
      res1.dest_offset = dst_inc;
      res1.last        = 1'b1;
      push_n           = n_copy;
    end
  end

  always_comb begin
    src_d        = src_q;
    dst_d        = dst_q;
    cs_d         = cs_q;
    bytes_d      = bytes_q;
    blank_d      = blank_q;
    blank_mode_d = blank_mode_q;
    div_d        = div_q;

    if (in_acc) begin
      case (cmd)
        CMD_WRITE: begin
          if (color_mode_q) begin
            case (sel)
              SEL_SRC_HI: src_d = {wdata, src_q[7:0]};
              SEL_SRC_LO: src_d = {src_q[15:8], wdata[7:4], 4'h0};
              SEL_DST_HI: dst_d = {wdata[4:0], dst_q[7:0]};
              SEL_DST_LO: dst_d = {dst_q[12:8], wdata[7:4], 4'h0};
              SEL_CONTROL: begin
                if ((phase_q == PH_INACTIVE) || wdata[7]) begin
                  // Start or restart a transfer.
                  blank_mode_d = wdata[7];
                  bytes_d      = {({1'b0, wdata[6:0]} + 8'd1), 4'h0};
                  blank_d      = 5'd16;
                  cs_d         = {1'b0, wdata[6:0]};
                  div_d        = 3'd4;
                end else begin
                  // Cancel the running transfer.
                  cs_d    = {1'b1, wdata[6:0]};
                  bytes_d = '0;
                  blank_d = '0;
                end
              end
              default: ;
            endcase
          end
        end
        CMD_READ: ;
        CMD_TICK: begin
          if ((phase_q == PH_STARTING) || (phase_q == PH_ACTIVE)) begin
            if (div_dec == 3'd0) begin
              div_d = 3'd4;
              if (phase_q == PH_ACTIVE) begin
                src_d   = src_q + {14'd0, n_copy};
                dst_d   = dst_q + {11'd0, n_copy};
                bytes_d = bytes_left;
                blank_d = blank_left;
                cs_d    = {1'b0, bytes_left[10:4] - 7'd1};
                if (bytes_left == 12'd0) begin
                  cs_d = 8'hFF;
                end
              end
            end else begin
              div_d = div_dec;
            end
          end else begin
            div_d = 3'd0;
          end
        end
        CMD_HBLANK: begin
          if (phase_q == PH_PAUSED) begin
            blank_d = 5'd16;
            div_d   = 3'd4;
          end
        end
        default: ;
      endcase
    end
  end

  // Configuration port: a single one-bit register, always ready.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_comb begin
    color_mode_d = color_mode_q;
    if (cfg_wr && (paddr[2] == CFG_IDX_COLOR_MODE)) begin
      color_mode_d = pwdata[0];
    end
  end

  assign prdata = (paddr[2] == CFG_IDX_COLOR_MODE) ? {31'd0, color_mode_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      color_mode_q <= 1'b1;
      src_q        <= '0;
      dst_q        <= '0;
      cs_q         <= '0;
      bytes_q      <= '0;
      blank_q      <= '0;
      phase_q      <= PH_INACTIVE;
      blank_mode_q <= 1'b0;
      div_q        <= '0;
    end else begin
      color_mode_q <= color_mode_d;
      src_q        <= src_d;
      dst_q        <= dst_d;
      cs_q         <= cs_d;
      bytes_q      <= bytes_d;
      blank_q      <= blank_d;
      phase_q      <= phase_d;
      blank_mode_q <= blank_mode_d;
      div_q        <= div_d;
    end
  end

  // Result queue decouples the burst of up to two results from the master side.
  vbdma_out_fifo u_out_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_n_i (push_n),
    .push0_i  (res0),
    .push1_i  (res1),
    .space_o  (q_space),
    .valid_o  (m_axis_tvalid),
    .data_o   (q_data),
    .pop_i    (m_axis_tready)
  );

  assign m_axis_tdata = {3'b000, q_data.dest_offset, q_data.source_addr, q_data.read_data};
  assign m_axis_tuser = q_data.copy_valid;
  assign m_axis_tlast = q_data.last;

endmodule
